// ----- design/tcw_pkg.sv -----
// tcw_pkg: shared types and constants of the text console writer.
// Transaction payload structs, action codes, character codes, register map and status codes.
// No dependencies.
package tcw_pkg;

  // Action codes carried in in_item_t.action
  localparam logic [2:0] ActWriteCursor = 3'd0;
  localparam logic [2:0] ActWritePos    = 3'd1;
  localparam logic [2:0] ActClear       = 3'd2;
  localparam logic [2:0] ActBackspace   = 3'd3;
  localparam logic [2:0] ActRead        = 3'd4;

  localparam logic [7:0] NewlineChar = 8'd10;
  localparam logic [7:0] SpaceChar   = 8'd32;

  // Register map
  localparam logic [2:0] AddrDefaultAttr  = 3'd0;
  localparam logic [7:0] DefaultAttrReset = 8'd15;

  localparam logic StatusDone    = 1'b0;
  localparam logic StatusOutside = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] line;
    logic [7:0] attribute;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [6:0] cursor_column;
    logic [4:0] cursor_line;
    logic       scrolled;
    logic [7:0] cell_character;
    logic [7:0] cell_attribute;
  } out_item_t;

endpackage

// ----- design/text_console_writer.sv -----
// text_console_writer: text-mode console engine, ROWS x COLS cells plus cursor.
// Screen held in one synchronous single-write, single-read memory.
// Depends on tcw_pkg.

// The screen is a memory of ROWS*COLS 16-bit cells (character in the low byte,
// attribute in the high byte) with one write port and one read port whose data
// is registered; the cursor is kept as a row/column pair. One transaction is
// worked on at a time. A write, newline, backspace or ignored action passes
// through ST_OUT to the result register; a cell read goes through ST_READ and
// ST_OUT. A write past the last cell, or a newline on the last row, scrolls:
// the copy walks the memory one cell per cycle and then blanks the last row.
// Clear fills every cell, one per cycle. After reset a clearing pass zeroes
// the screen while the input stays stalled; the register port works
// throughout. The single memory write port sets all sweep lengths. The result
// register lets a new transaction be accepted while the previous result still
// waits downstream.
module text_console_writer #(
  parameter int unsigned COLS = 80,   // 8 .. 128
  parameter int unsigned ROWS = 25    // 2 .. 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcw_pkg::in_item_t   in_data_i,
  // result transactions
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcw_pkg::out_item_t  out_data_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Cells);

  localparam logic [CW-1:0] LastCol  = CW'(COLS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [AW-1:0] ColsA    = AW'(COLS);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
  localparam logic [AW-1:0] CopyEnd  = AW'(Cells - COLS);
  localparam logic [7:0]    ColsW    = 8'(COLS);
  localparam logic [5:0]    RowsW    = 6'(ROWS);

  typedef enum logic [2:0] {
    ST_INIT,    // zeroing pass after reset
    ST_IDLE,    // waiting for a transaction
    ST_READ,    // cell read data arrives
    ST_SCROLL,  // copy row r+1 into row r, cell by cell
    ST_BLANK,   // zero the last row
    ST_FILL,    // clear: spaces with default attribute
    ST_OUT      // hand the result to the output register
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(AW'(r) * ColsA) + AW'(c);
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [RW-1:0]      cur_row_q, cur_row_d;
  logic [CW-1:0]      cur_col_q, cur_col_d;
  logic               pend_status_q, pend_status_d;
  logic               pend_scrolled_q, pend_scrolled_d;
  logic [15:0]        pend_cell_q, pend_cell_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_item_t out_q, out_d;
  logic [7:0]         dattr_q, dattr_d;

  // screen memory
  logic [15:0]   screen_mem [Cells];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata_q;

  // decode of the incoming transaction
  logic          on_screen;
  logic          is_nl;
  logic [RW-1:0] put_row;
  logic [CW-1:0] put_col;
  logic [7:0]    put_attr;
  logic [RW-1:0] bs_row;
  logic [CW-1:0] bs_col;
  logic          cfg_wr;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign prdata      = (paddr[2] == tcw_pkg::AddrDefaultAttr[2]) ? {24'd0, dattr_q} : 32'd0;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign on_screen = ({1'b0, in_data_i.column} < ColsW) && ({1'b0, in_data_i.line} < RowsW);
  assign is_nl     = (in_data_i.character == tcw_pkg::NewlineChar);
  assign put_attr  = (in_data_i.attribute != 8'd0) ? in_data_i.attribute : dattr_q;

  always_comb begin
    if (in_data_i.action == tcw_pkg::ActWritePos) begin
      put_row = in_data_i.line[RW-1:0];
      put_col = in_data_i.column[CW-1:0];
    end else begin
      put_row = cur_row_q;
      put_col = cur_col_q;
    end
  end

  // backspace target, saturating at the home cell
  always_comb begin
    bs_row = cur_row_q;
    bs_col = cur_col_q;
    if (cur_col_q != '0) begin
      bs_col = cur_col_q - CW'(1);
    end else if (cur_row_q != '0) begin
      bs_row = cur_row_q - RW'(1);
      bs_col = LastCol;
    end
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cur_row_d       = cur_row_q;
    cur_col_d       = cur_col_q;
    pend_status_d   = pend_status_q;
    pend_scrolled_d = pend_scrolled_q;
    pend_cell_d     = pend_cell_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_d           = out_q;
    dattr_d         = dattr_q;
    mem_we          = 1'b0;
    mem_waddr       = cnt_q;
    mem_wdata       = 16'd0;
    mem_raddr       = cnt_q + ColsA;

    if (cfg_wr && (paddr[2] == tcw_pkg::AddrDefaultAttr[2])) begin
      dattr_d = pwdata[7:0];
    end

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          pend_status_d   = tcw_pkg::StatusDone;
          pend_scrolled_d = 1'b0;
          pend_cell_d     = 16'd0;
          state_d         = ST_OUT;
          case (in_data_i.action)
            tcw_pkg::ActWriteCursor, tcw_pkg::ActWritePos: begin
              if ((in_data_i.action == tcw_pkg::ActWritePos) && !on_screen) begin
                pend_status_d = tcw_pkg::StatusOutside;
              end else begin
                if (!is_nl) begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(put_row, put_col);
                  mem_wdata = {put_attr, in_data_i.character};
                end
                if (is_nl || (put_col == LastCol)) begin
                  cur_col_d = '0;
                  if (put_row == LastRow) begin
                    // ran off the bottom: scroll, cursor to start of last row
                    cur_row_d       = LastRow;
                    pend_scrolled_d = 1'b1;
                    cnt_d           = '0;
                    state_d         = ST_SCROLL;
                  end else begin
                    cur_row_d = put_row + RW'(1);
                  end
                end else begin
                  cur_row_d = put_row;
                  cur_col_d = put_col + CW'(1);
                end
              end
            end
            tcw_pkg::ActClear: begin
              cur_row_d = '0;
              cur_col_d = '0;
              cnt_d     = '0;
              state_d   = ST_FILL;
            end
            tcw_pkg::ActBackspace: begin
              cur_row_d = bs_row;
              cur_col_d = bs_col;
              mem_we    = 1'b1;
              mem_waddr = cell_addr(bs_row, bs_col);
              mem_wdata = {dattr_q, tcw_pkg::SpaceChar};
            end
            tcw_pkg::ActRead: begin
              if (!on_screen) begin
                pend_status_d = tcw_pkg::StatusOutside;
              end else begin
                mem_raddr = cell_addr(in_data_i.line[RW-1:0], in_data_i.column[CW-1:0]);
                state_d   = ST_READ;
              end
            end
            default: begin
              // unknown action: report cursor only
            end
          endcase
        end
      end

      ST_READ: begin
        pend_cell_d = mem_rdata_q;
        state_d     = ST_OUT;
      end

      ST_SCROLL: begin
        // read cell cnt+COLS, write the previous read to cnt-1
        mem_raddr = cnt_q + ColsA;
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q - AW'(1);
          mem_wdata = mem_rdata_q;
        end
        if (cnt_q == CopyEnd) begin
          state_d = ST_BLANK;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      ST_BLANK: begin
        mem_we = 1'b1;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {dattr_q, tcw_pkg::SpaceChar};
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = pend_status_q;
          out_d.cursor_column  = 7'(cur_col_q);
          out_d.cursor_line    = 5'(cur_row_q);
          out_d.scrolled       = pend_scrolled_q;
          out_d.cell_character = pend_cell_q[7:0];
          out_d.cell_attribute = pend_cell_q[15:8];
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      out_valid_q <= 1'b0;
      dattr_q     <= tcw_pkg::DefaultAttrReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      out_valid_q <= out_valid_d;
      dattr_q     <= dattr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_status_q   <= pend_status_d;
    pend_scrolled_q <= pend_scrolled_d;
    pend_cell_q     <= pend_cell_d;
    out_q           <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= screen_mem[mem_raddr];
  end

  // cursor never leaves the screen
  a_cursor_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_row_q <= LastRow) && (cur_col_q <= LastCol))
    else $error("cursor outside screen");

  // memory writes stay inside the screen
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= LastCell))
    else $error("memory write beyond last cell");

  // a scrolled result always leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scrolled) |->
      ((out_q.cursor_column == 7'd0) && (out_q.cursor_line == 5'(ROWS - 1))))
    else $error("scroll left cursor misplaced");

  // an accepted transaction takes the engine out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("engine stayed idle after accept");

  // the scroll counter never passes the end of the copy
  a_scroll_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL) |-> (cnt_q <= CopyEnd))
    else $error("scroll counter overran");

endmodule
